// ===== src/ray_box_slab_test_macros.svh =====
// ----------------------------------------------------------------------------
// ray_box_slab_test_macros: assertion helpers
// concurrent assertion wrappers, empty when SYNTHESIS is defined
// ----------------------------------------------------------------------------
`ifndef RAY_BOX_SLAB_TEST_MACROS_SVH
`define RAY_BOX_SLAB_TEST_MACROS_SVH

`ifndef SYNTHESIS
// checked while out of reset
`define RBST_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rbst assertion failed");
// checked at every edge, reset included
`define RBST_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("rbst assertion failed");
`else
`define RBST_ASSERT(label, prop)
`define RBST_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== src/rbst_pkg.sv =====
// ----------------------------------------------------------------------------
// rbst_pkg: shared constants and types
// widths, saturation limits and register indexes of the slab test
// ----------------------------------------------------------------------------
`default_nettype none

package rbst_pkg;

    localparam int DIFF_W  = 34;       // bound minus origin
    localparam int DIR_W   = 32;
    localparam int T_W     = 32;
    localparam int QBITS   = 31;       // quotient bits before saturation
    localparam int NSTG    = 36;       // pipeline stages, accept to output
    localparam int ZS_W    = 21;
    localparam int ZERO_SCALE = 1000000;

    localparam logic [T_W-1:0] T_MAX = 32'h7fff_ffff;
    localparam logic [T_W-1:0] T_MIN = 32'h8000_0000;

    typedef enum logic [1:0] {
        REG_CENTER_X = 2'd0,
        REG_CENTER_Y = 2'd1,
        REG_CENTER_Z = 2'd2,
        REG_BOX_SIZE = 2'd3
    } cfg_idx_t;

endpackage

`default_nettype wire

// ===== src/rbst_div.sv =====
// ----------------------------------------------------------------------------
// rbst_div: pipelined saturating slab divider
// (diff << FRAC_BITS) / dir, one quotient bit per stage, zero dir fallback
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                clk,
    input  logic                                en,
    input  logic signed [rbst_pkg::DIFF_W-1:0]  diff,
    input  logic signed [rbst_pkg::DIR_W-1:0]   dir,
    output logic signed [rbst_pkg::T_W-1:0]     t
);
    import rbst_pkg::*;

    localparam int NW = DIFF_W + FRAC_BITS;
    localparam int HW = NW - QBITS;
    localparam int PW = DIFF_W + ZS_W;
    localparam logic signed [ZS_W-1:0] ZS = ZS_W'(ZERO_SCALE);

    // prep stage
    logic signed [NW-1:0]   num;
    logic [NW-1:0]          nmag;
    logic [DIR_W-1:0]       dmag;
    logic [HW-1:0]          nhi;
    logic                   ovf_next;
    logic signed [PW-1:0]   prod;
    logic                   zpos;
    logic                   zneg;
    logic [T_W-1:0]         zres_next;

    assign num  = $signed({diff, {FRAC_BITS{1'b0}}});
    assign nmag = diff[DIFF_W-1] ? NW'(-num) : NW'(num);
    assign dmag = dir[DIR_W-1] ? DIR_W'(-dir) : DIR_W'(dir);
    assign nhi  = nmag[NW-1:QBITS];
    assign ovf_next = {{(DIR_W-HW){1'b0}}, nhi} >= dmag;

    assign prod = diff * ZS;
    assign zpos = !prod[PW-1] && (|prod[PW-2:T_W-1]);
    assign zneg = prod[PW-1] && !(&prod[PW-2:T_W-1]);
    assign zres_next = zpos ? T_MAX : (zneg ? T_MIN : prod[T_W-1:0]);

    logic [DIR_W-1:0]   r_reg    [0:QBITS-1];
    logic [QBITS-1:0]   low_reg  [0:QBITS-1];
    logic [DIR_W-1:0]   dmag_reg [0:QBITS-1];
    logic [QBITS-1:0]   q_reg    [0:QBITS];
    logic               neg_reg  [0:QBITS];
    logic               zero_reg [0:QBITS];
    logic               ovf_reg  [0:QBITS];
    logic [T_W-1:0]     zres_reg [0:QBITS];
    logic [T_W-1:0]     t_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= {{(DIR_W-HW){1'b0}}, nhi};
            low_reg[0]  <= nmag[QBITS-1:0];
            dmag_reg[0] <= dmag;
            q_reg[0]    <= '0;
            neg_reg[0]  <= diff[DIFF_W-1] ^ dir[DIR_W-1];
            zero_reg[0] <= (dir == '0);
            ovf_reg[0]  <= ovf_next;
            zres_reg[0] <= zres_next;
        end
    end

    // restoring division, one bit a stage
    for (genvar k = 0; k < QBITS; k++)
    begin : g_step
        logic [DIR_W:0] tr;
        logic [DIR_W:0] r_next;
        logic           ge;

        assign tr     = {r_reg[k], low_reg[k][QBITS-1]};
        assign ge     = tr >= {1'b0, dmag_reg[k]};
        assign r_next = ge ? (tr - {1'b0, dmag_reg[k]}) : tr;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]    <= {q_reg[k][QBITS-2:0], ge};
                neg_reg[k+1]  <= neg_reg[k];
                zero_reg[k+1] <= zero_reg[k];
                ovf_reg[k+1]  <= ovf_reg[k];
                zres_reg[k+1] <= zres_reg[k];
            end
        end

        if (k < QBITS - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k+1]    <= r_next[DIR_W-1:0];
                    low_reg[k+1]  <= {low_reg[k][QBITS-2:0], 1'b0};
                    dmag_reg[k+1] <= dmag_reg[k];
                end
            end
        end
    end

    // sign and saturation
    logic [T_W-1:0] qext;
    assign qext = {1'b0, q_reg[QBITS]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (zero_reg[QBITS])
                t_reg <= zres_reg[QBITS];
            else if (ovf_reg[QBITS])
                t_reg <= neg_reg[QBITS] ? T_MIN : T_MAX;
            else
                t_reg <= neg_reg[QBITS] ? T_W'(-qext) : qext;
        end
    end

    assign t = $signed(t_reg);

endmodule

`default_nettype wire

// ===== src/rbst_lane.sv =====
// ----------------------------------------------------------------------------
// rbst_lane: one axis of the slab test
// slab differences, two dividers, per-axis min and max
// ----------------------------------------------------------------------------
`default_nettype none

module rbst_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic signed [rbst_pkg::T_W-1:0]  lo,
    input  logic signed [rbst_pkg::T_W-1:0]  hi,
    input  logic signed [30:0]               org,
    input  logic signed [rbst_pkg::DIR_W-1:0] dir,
    output logic signed [rbst_pkg::T_W-1:0]  tmin,
    output logic signed [rbst_pkg::T_W-1:0]  tmax
);
    import rbst_pkg::*;

    logic signed [DIFF_W-1:0] dlo_reg;
    logic signed [DIFF_W-1:0] dhi_reg;
    logic signed [DIR_W-1:0]  dir_reg;
    logic signed [T_W-1:0]    ta;
    logic signed [T_W-1:0]    tb;
    logic signed [T_W-1:0]    tmin_reg;
    logic signed [T_W-1:0]    tmax_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dlo_reg <= DIFF_W'(lo) - DIFF_W'(org);
            dhi_reg <= DIFF_W'(hi) - DIFF_W'(org);
            dir_reg <= dir;
        end
    end

    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_lo (
        .clk  (clk),
        .en   (en),
        .diff (dlo_reg),
        .dir  (dir_reg),
        .t    (ta)
    );

    rbst_div #(.FRAC_BITS(FRAC_BITS)) u_div_hi (
        .clk  (clk),
        .en   (en),
        .diff (dhi_reg),
        .dir  (dir_reg),
        .t    (tb)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tmin_reg <= (ta < tb) ? ta : tb;
            tmax_reg <= (ta < tb) ? tb : ta;
        end
    end

    assign tmin = tmin_reg;
    assign tmax = tmax_reg;

endmodule

`default_nettype wire

// ===== src/ray_box_slab_test.sv =====
// ----------------------------------------------------------------------------
// ray_box_slab_test: ray against axis-aligned box, slab method
// three axis lanes in parallel, merged into entry/exit distance and hit
// ----------------------------------------------------------------------------
// usage
//   input channel: one beat per ray (origin signed Q15.16, direction signed
//   Q16.16), accepted when in_valid is high and in_stall low
//   output channel: one beat per ray (hit, t_near, t_far), taken when
//   out_valid is high and out_stall low
//   config channel: cfg_index/cfg_data written when cfg_valid and cfg_ready
//   are high; cfg_ready is always high, write only while the block is idle
//   path: lane difference, divider prep, quotient steps, saturation,
//   lane min/max and merge register, each registered in turn
//   throughput: one ray per cycle while the skid is empty; each lane runs two
//   restoring dividers that retire one quotient bit per stage, which sets the pipeline depth
//   stall: a 1-entry skid register catches the beat leaving the pipe while
//   out_stall is high; the pipe freezes and in_stall rises only while the
//   skid holds a beat, so one more ray is taken while a result waits
//   reset: pipe and skid emptied, box at origin with edge 1.0
// ----------------------------------------------------------------------------
`default_nettype none

`include "ray_box_slab_test_macros.svh"

module ray_box_slab_test #(
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // config writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    // ray beats
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic signed [30:0]   origin_x,
    input  logic signed [30:0]   origin_y,
    input  logic signed [30:0]   origin_z,
    input  logic signed [31:0]   dir_x,
    input  logic signed [31:0]   dir_y,
    input  logic signed [31:0]   dir_z,
    // result beats
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [30:0]          t_near,
    output logic signed [31:0]   t_far
);
    import rbst_pkg::*;

    // box registers
    logic signed [30:0] cx_reg;
    logic signed [30:0] cy_reg;
    logic signed [30:0] cz_reg;
    logic [29:0]        size_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg   <= '0;
            cy_reg   <= '0;
            cz_reg   <= '0;
            size_reg <= 30'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CENTER_X: cx_reg   <= cfg_data[30:0];
                REG_CENTER_Y: cy_reg   <= cfg_data[30:0];
                REG_CENTER_Z: cz_reg   <= cfg_data[30:0];
                REG_BOX_SIZE: size_reg <= cfg_data[29:0];
                default:      ;
            endcase
        end
    end

    // slab bounds, stable between config writes
    logic signed [T_W-1:0] half;
    logic signed [T_W-1:0] lo_x, hi_x, lo_y, hi_y, lo_z, hi_z;

    assign half = $signed({3'b000, size_reg[29:1]});
    assign lo_x = T_W'(cx_reg) - half;
    assign hi_x = T_W'(cx_reg) + half;
    assign lo_y = T_W'(cy_reg);
    assign hi_y = T_W'(cy_reg) + $signed({2'b00, size_reg});
    assign lo_z = T_W'(cz_reg) - half;
    assign hi_z = T_W'(cz_reg) + half;

    // pipe control: whole pipe advances unless the skid is full
    logic            en;
    logic [NSTG-1:0] v_reg;
    logic            skid_v_reg;

    assign en       = !skid_v_reg;
    assign in_stall = skid_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (en)
            v_reg <= {v_reg[NSTG-2:0], in_valid};
    end

    // axis lanes
    logic signed [T_W-1:0] mnx, mxx, mny, mxy, mnz, mxz;

    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
        .clk (clk), .en (en), .lo (lo_x), .hi (hi_x),
        .org (origin_x), .dir (dir_x), .tmin (mnx), .tmax (mxx)
    );

    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
        .clk (clk), .en (en), .lo (lo_y), .hi (hi_y),
        .org (origin_y), .dir (dir_y), .tmin (mny), .tmax (mxy)
    );

    rbst_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
        .clk (clk), .en (en), .lo (lo_z), .hi (hi_z),
        .org (origin_z), .dir (dir_z), .tmin (mnz), .tmax (mxz)
    );

    // merge: latest entry clamped at zero, earliest exit
    logic signed [T_W-1:0] tn_next;
    logic signed [T_W-1:0] tf_next;
    logic                  hit_next;

    always_comb
    begin
        tn_next = '0;
        if (mnx > tn_next) tn_next = mnx;
        if (mny > tn_next) tn_next = mny;
        if (mnz > tn_next) tn_next = mnz;
        tf_next = mxx;
        if (mxy < tf_next) tf_next = mxy;
        if (mxz < tf_next) tf_next = mxz;
        hit_next = (tn_next <= tf_next) && !tf_next[T_W-1];
    end

    logic                  hit_reg;
    logic [30:0]           tn_reg;
    logic signed [T_W-1:0] tf_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg <= hit_next;
            tn_reg  <= tn_next[30:0];
            tf_reg  <= tf_next;
        end
    end

    // skid register, holds the older beat while the receiver stalls
    logic                  skid_hit_reg;
    logic [30:0]           skid_tn_reg;
    logic signed [T_W-1:0] skid_tf_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_v_reg <= 1'b0;
        else if (skid_v_reg)
            skid_v_reg <= out_stall;
        else
            skid_v_reg <= v_reg[NSTG-1] && out_stall;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_v_reg)
        begin
            skid_hit_reg <= hit_reg;
            skid_tn_reg  <= tn_reg;
            skid_tf_reg  <= tf_reg;
        end
    end

    assign out_valid = skid_v_reg || v_reg[NSTG-1];
    assign hit       = skid_v_reg ? skid_hit_reg : hit_reg;
    assign t_near    = skid_v_reg ? skid_tn_reg  : tn_reg;
    assign t_far     = skid_v_reg ? skid_tf_reg  : tf_reg;

    // checks
    `RBST_ASSERT(a_hit_order, out_valid && hit |-> ($signed({1'b0, t_near}) <= t_far))
    `RBST_ASSERT(a_hit_ahead, out_valid && t_far[T_W-1] |-> !hit)
    `RBST_ASSERT(a_skid_freeze, skid_v_reg && out_stall |=> skid_v_reg && $stable(v_reg))
    `RBST_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !skid_v_reg)

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: ray against box slab test bench
// rays are sent through the block and each result beat is checked against
// the slab predictor or a hand-typed result; box settings change between phases
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    import rbst_pkg::*;

    localparam int  N_RANDOM    = 450;
    localparam int  DRAIN_WAIT  = NSTG + 20;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [30:0] ox;
        logic signed [30:0] oy;
        logic signed [30:0] oz;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
    } ray_t;

    typedef struct packed {
        logic        hit;
        logic [30:0] t_near;
        logic [31:0] t_far;
    } hit_info_t;

    // one row of the directed table; known = result typed in by hand
    typedef struct {
        ray_t      ray;
        bit        known;
        hit_info_t res;
    } ray_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [31:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [30:0] origin_x = '0, origin_y = '0, origin_z = '0;
    logic signed [31:0] dir_x = '0, dir_y = '0, dir_z = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic hit;
    logic [30:0] t_near;
    logic signed [31:0] t_far;

    always #5 clk = ~clk;

    ray_box_slab_test u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall),
        .origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
        .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
        .out_valid(out_valid), .out_stall(out_stall),
        .hit(hit), .t_near(t_near), .t_far(t_far)
    );

    // predictor copy of the box registers
    logic signed [63:0] box_cx, box_cy, box_cz, box_edge;

    hit_info_t expected_hits[$];
    int  mismatch_count = 0;
    int  beats_checked = 0;
    int  hits_seen = 0;
    longint cycle_count = 0;

    // idling controls
    bit  quiet_mode = 1'b0;   // no idling on either side
    bit  hold_rx    = 1'b0;   // long receiver hold-off
    int  hold_len   = 0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at beat %0d: %s got %0d want %0d", beats_checked, what, got, want);
        mismatch_count++;
    endtask

    function automatic logic signed [63:0] sat_t(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // distance to one slab plane; zero direction scales by the epsilon reciprocal
    function automatic logic signed [63:0] plane_dist(input logic signed [63:0] diff,
                                                      input logic signed [63:0] dir);
        if (dir == 0) return sat_t(diff * 64'sd1000000);
        return sat_t((diff * 64'sd65536) / dir);
    endfunction

    function automatic hit_info_t predict_slab(input ray_t r);
        logic signed [63:0] half, lo[3], hi[3], org[3], dir[3], a, b, tn, tf;
        hit_info_t res;
        half = box_edge >>> 1;
        lo[0] = box_cx - half; hi[0] = box_cx + half;
        lo[1] = box_cy;        hi[1] = box_cy + box_edge;
        lo[2] = box_cz - half; hi[2] = box_cz + half;
        org[0] = r.ox; org[1] = r.oy; org[2] = r.oz;
        dir[0] = r.dx; dir[1] = r.dy; dir[2] = r.dz;
        tn = 0;
        tf = 64'sd2147483647;
        for (int ax = 0; ax < 3; ax++)
        begin
            a = plane_dist(lo[ax] - org[ax], dir[ax]);
            b = plane_dist(hi[ax] - org[ax], dir[ax]);
            if (a > b)
            begin
                tn = (b > tn) ? b : tn;
                tf = (a < tf) ? a : tf;
            end
            else
            begin
                tn = (a > tn) ? a : tn;
                tf = (b < tf) ? b : tf;
            end
        end
        res.hit = (tn <= tf) && (tf >= 0);
        res.t_near = tn[30:0];
        res.t_far = tf[31:0];
        return res;
    endfunction

    // one register write; set_box drops cfg_valid after the last one
    task automatic write_box_reg(input cfg_idx_t idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_CENTER_X: box_cx = $signed(val[30:0]);
            REG_CENTER_Y: box_cy = $signed(val[30:0]);
            REG_CENTER_Z: box_cz = $signed(val[30:0]);
            REG_BOX_SIZE: box_edge = {34'd0, val[29:0]};
            default:      ;
        endcase
    endtask

    task automatic set_box(input logic [31:0] cx, cy, cz, edge_len);
        write_box_reg(REG_CENTER_X, cx);
        write_box_reg(REG_CENTER_Y, cy);
        write_box_reg(REG_CENTER_Z, cz);
        write_box_reg(REG_BOX_SIZE, edge_len);
        cfg_valid <= 1'b0;
    endtask

    // stop offering, wait for every expected beat, then for the pipe to go quiet
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    // offer one ray beat, holding it until accepted; random idle beforehand
    task automatic send_ray(input ray_t r, input bit known, input hit_info_t res);
        while (!quiet_mode && $urandom_range(99) < 22)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        {origin_x, origin_y, origin_z, dir_x, dir_y, dir_z} <= r;
        expected_hits.push_back(known ? res : predict_slab(r));
        do @(posedge clk); while (in_stall);
    endtask

    function automatic logic [31:0] rand_field(input int w);
        logic [31:0] v;
        case ($urandom_range(5))
            0: v = 32'd0;
            1: v = 32'h4000_0000 >> (32 - w + 0);
            2: v = $urandom_range(262144);
            3: v = -$urandom_range(262144);
            default: v = $urandom;
        endcase
        return (w == 31) ? {{2{v[30]}}, v[29:0]} : v;
    endfunction

    // mostly rays aimed near the box so hits and misses both occur
    function automatic ray_t rand_ray();
        ray_t r;
        if ($urandom_range(99) < 70)
        begin
            r.ox = 31'(box_cx + $signed($urandom_range(1 << 20)) - (1 << 19));
            r.oy = 31'(box_cy + $signed($urandom_range(1 << 20)) - (1 << 19));
            r.oz = 31'(box_cz + $signed($urandom_range(1 << 20)) - (1 << 19));
            r.dx = $signed($urandom_range(1 << 18)) - (1 << 17);
            r.dy = $signed($urandom_range(1 << 18)) - (1 << 17);
            r.dz = $signed($urandom_range(1 << 18)) - (1 << 17);
            if ($urandom_range(9) == 0) r.dx = 0;
            if ($urandom_range(9) == 0) r.dy = 0;
            if ($urandom_range(9) == 0) r.dz = 0;
        end
        else
        begin
            r.ox = 31'(rand_field(31));
            r.oy = 31'(rand_field(31));
            r.oz = 31'(rand_field(31));
            r.dx = rand_field(32); r.dy = rand_field(32); r.dz = rand_field(32);
        end
        return r;
    endfunction

    // receiver: stall at random, long hold-off when asked
    always @(posedge clk)
    begin
        if (hold_rx)
            out_stall <= 1'b1;
        else if (quiet_mode)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 22);
    end

    // result checker, sampled at the edge that takes the beat
    always @(posedge clk)
    begin
        cycle_count++;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_hits.size() == 0)
            begin
                report_mismatch("beat with nothing expected, t_far", t_far, 0);
            end
            else
            begin
                hit_info_t want;
                want = expected_hits.pop_front();
                if (hit !== want.hit) report_mismatch("hit", hit, want.hit);
                if (t_near !== want.t_near) report_mismatch("t_near", t_near, want.t_near);
                if (t_far !== want.t_far)
                    report_mismatch("t_far", t_far, $signed(want.t_far));
                hits_seen += want.hit;
            end
            beats_checked++;
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // long receiver hold-off, counted here in cycles
    task automatic receiver_hold(input int cycles);
        hold_rx = 1'b1;
        repeat (cycles) @(posedge clk);
        hold_rx = 1'b0;
    endtask

    ray_row_t rays[$];
    hit_info_t none;

    function automatic ray_row_t mk(input logic [30:0] ox, oy, oz,
                                    input logic [31:0] dx, dy, dz,
                                    input bit known = 0, input hit_info_t res = '0);
        ray_row_t row;
        row.ray = '{ox, oy, oz, dx, dy, dz};
        row.known = known;
        row.res = res;
        return row;
    endfunction

    initial
    begin
        ray_t r;
        none = '0;
        box_cx = 0; box_cy = 0; box_cz = 0; box_edge = 65536;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, reset box (edge 1.0 at origin)
        // ray from below along +y with unit step: enters at 1.0, leaves at 2.0
        rays.push_back(mk(0, -31'sd65536, 0, 0, 32'sd65536, 0,
                          1, '{1'b1, 31'd65536, 32'd131072}));
        // origin inside box, all direction zero: x,z diffs straddle, y lo=0
        rays.push_back(mk(0, 32768, 0, 0, 0, 0));
        // extremes of origin and direction
        rays.push_back(mk(31'h3fff_ffff, 31'h3fff_ffff, 31'h3fff_ffff,
                          32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
        rays.push_back(mk(31'h4000_0000, 31'h4000_0000, 31'h4000_0000,
                          32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
        rays.push_back(mk(31'h4000_0000, 0, 0, 32'h0000_0001, 32'hffff_ffff, 1));
        rays.push_back(mk(31'h3fff_ffff, 0, 0, 32'hffff_ffff, 1, 0));
        // pointing away: miss, t_far negative
        rays.push_back(mk(0, -31'sd131072, 0, 0, -32'sd65536, 0));
        // zero direction outside the slab saturates
        rays.push_back(mk(31'sd200000, 0, 0, 0, 32'sd65536, 0));
        rays.push_back(mk(-31'sd200000, 0, 0, 0, 32'sd65536, 0));
        // diagonal ray
        rays.push_back(mk(-31'sd131072, -31'sd131072, -31'sd131072,
                          32'sd65536, 32'sd65536, 32'sd65536));
        foreach (rays[i]) send_ray(rays[i].ray, rays[i].known, rays[i].res);
        wait_idle();

        // degenerate box, extremes of the registers, then odd size
        set_box(0, 0, 0, 0);
        send_ray('{0, -31'sd65536, 0, 0, 32'sd65536, 0}, 0, none);
        send_ray('{0, 0, 0, 0, 0, 0}, 0, none);
        send_ray('{1, 1, 1, 1, 1, 1}, 0, none);
        wait_idle();
        set_box(32'h3fff_ffff, 32'h4000_0000, 32'h3fff_ffff, 32'h3fff_ffff);
        send_ray('{0, 0, 0, 32'sd65536, 32'sd65536, 32'sd65536}, 0, none);
        send_ray('{31'h4000_0000, 31'h3fff_ffff, 31'h4000_0000,
                   32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000}, 0, none);
        wait_idle();
        set_box(32'h4000_0000, 32'h3fff_ffff, 32'h4000_0000, 32'd3);
        send_ray('{0, 0, 0, -32'sd65536, 32'sd65536, -32'sd65536}, 0, none);
        wait_idle();

        // random phases, each with its own box; last phase runs without idling
        for (int ph = 0; ph < 6; ph++)
        begin
            set_box($urandom_range(1 << 22) - (1 << 21), $urandom_range(1 << 22) - (1 << 21),
                    $urandom_range(1 << 22) - (1 << 21),
                    (ph == 0) ? 32'd1 : $urandom_range(1 << 20));
            quiet_mode = (ph == 5);
            for (int i = 0; i < N_RANDOM / 6; i++)
            begin
                if (ph == 2 && i == 10)
                begin
                    // hold the receiver while rays keep coming to fill the pipe
                    fork
                        receiver_hold(3 * NSTG);
                    join_none
                end
                if (ph == 3 && i == 40)
                begin
                    // sender pauses until every result is back
                    in_valid <= 1'b0;
                    while (expected_hits.size() != 0) @(posedge clk);
                end
                r = rand_ray();
                send_ray(r, 0, none);
            end
            wait_idle();
        end
        quiet_mode = 1'b0;

        $display("checked %0d result beats (%0d hits) over several box settings",
                 beats_checked, hits_seen);
        if (mismatch_count == 0 && expected_hits.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
